>>> rtl/core/lgs_pkg.sv
// Shared types and constants for the life generation stencil core.
// No dependencies; compile first.
package lgs_pkg;

  localparam int unsigned CFG_W   = 6;
  localparam int unsigned COORD_W = 5;
  localparam int unsigned RES_MAX = 4;

  localparam logic [CFG_W-1:0] GRID_ROWS_RST = 6'd25;
  localparam logic [CFG_W-1:0] GRID_COLS_RST = 6'd25;

  typedef enum logic [0:0] {
    CFG_GRID_ROWS = 1'b0,
    CFG_GRID_COLS = 1'b1
  } cfg_idx_t;

  // column slice of the window: [0] two rows up, [1] row above, [2] current row
  typedef logic [2:0] win_t;

  typedef struct packed {
    logic load;
    logic shift;
    logic clear;
    logic din;
  } cell_ctl_t;

  typedef struct packed {
    logic               next_alive;
    logic [COORD_W-1:0] out_row;
    logic [COORD_W-1:0] out_col;
    logic               grid_done;
  } res_t;

endpackage

>>> rtl/core/lgs_chan_if.sv
// Valid/ready channel interfaces for cell words in and result words out.
// Depends on lgs_pkg.
interface lgs_in_if;
  logic valid;
  logic ready;
  logic cell_alive;

  modport source (output valid, output cell_alive, input ready);
  modport sink (input valid, input cell_alive, output ready);
endinterface

interface lgs_out_if;
  import lgs_pkg::*;
  logic               valid;
  logic               ready;
  logic               next_alive;
  logic [COORD_W-1:0] out_row;
  logic [COORD_W-1:0] out_col;
  logic               grid_done;

  modport source (output valid, output next_alive, output out_row, output out_col,
                  output grid_done, input ready);
  modport sink (input valid, input next_alive, input out_row, input out_col,
                input grid_done, output ready);
endinterface

>>> rtl/core/lgs_cell.sv
// One column cell: holds three window rows of one column and evaluates the
// life rule for its column from its own and its neighbors' bits. Depends on lgs_pkg.
module lgs_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  lgs_pkg::cell_ctl_t ctl,
  input  logic               wr_en,
  input  logic               in_grid,
  input  lgs_pkg::win_t      left_bits,
  input  lgs_pkg::win_t      right_bits,
  output lgs_pkg::win_t      own_bits,
  output logic               life_mid,
  output logic               life_bot
);
  import lgs_pkg::*;

  win_t win_r;
  win_t win_nxt;
  win_t staged;

  function automatic logic life_rule(input logic self_alive, input logic [3:0] n);
    life_rule = self_alive ? (n == 4'd2 || n == 4'd3) : (n == 4'd3);
  endfunction

  always_comb begin
    staged = ctl.shift ? {1'b0, win_r[2:1]} : win_r;
    if (wr_en) begin
      staged[2] = ctl.din;
    end
    win_nxt = ctl.clear ? '0 : staged;
  end

  assign own_bits = in_grid ? staged : '0;

  always_comb begin
    logic [3:0] n_mid;
    logic [3:0] n_bot;
    n_mid = 4'(left_bits[0]) + 4'(left_bits[1]) + 4'(left_bits[2])
          + 4'(right_bits[0]) + 4'(right_bits[1]) + 4'(right_bits[2])
          + 4'(own_bits[0]) + 4'(own_bits[2]);
    n_bot = 4'(left_bits[1]) + 4'(left_bits[2])
          + 4'(right_bits[1]) + 4'(right_bits[2]) + 4'(own_bits[1]);
    life_mid = life_rule(own_bits[1], n_mid);
    life_bot = life_rule(own_bits[2], n_bot);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (ctl.load) begin
      win_r <= win_nxt;
    end
  end

endmodule

>>> rtl/core/life_generation_stencil_core.sv
// Top level of the life generation stencil: a row of column cells holding a
// three-row window, counters, configuration and a four-word result buffer.
// Depends on lgs_pkg, lgs_chan_if and lgs_cell.
//
// One generation of Conway's Life on a grid of grid_rows x grid_cols (clamped
// to 1..MAX_ROWS and 1..MAX_COLS), cells streamed one bit per word in raster
// order, cells outside the grid dead. A cell's result leaves as soon as the
// row below it has reached the next column, with its row and column; the last
// result of a grid has grid_done set, after which the window and counters
// start over. One word is taken per clock while each word yields at most one
// result and the output is ready (every word but the last of a row, outside
// the last row); the buffer drains one word per clock while the output is
// ready, and the next input is taken in the cycle its last result leaves.
// A word's first result is registered and offered in the cycle after it is taken.
module life_generation_stencil_core #(
  parameter int unsigned MAX_COLS = 32,
  parameter int unsigned MAX_ROWS = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  lgs_pkg::cfg_idx_t                cfg_index,
  input  logic [lgs_pkg::CFG_W-1:0]        cfg_wdata,
  lgs_in_if.sink                           in_chan,
  lgs_out_if.source                        out_chan
);
  import lgs_pkg::*;

  localparam int unsigned CLW = $clog2(MAX_COLS);
  localparam int unsigned RLW = $clog2(MAX_ROWS);
  localparam int unsigned CCW = ($clog2(MAX_COLS + 1) > CFG_W + 1) ?
                                $clog2(MAX_COLS + 1) : CFG_W + 1;
  localparam int unsigned RCW = ($clog2(MAX_ROWS + 1) > CFG_W + 1) ?
                                $clog2(MAX_ROWS + 1) : CFG_W + 1;
  localparam int unsigned CXW = (CLW > COORD_W) ? CLW : COORD_W;
  localparam int unsigned RXW = (RLW > COORD_W) ? RLW : COORD_W;

  logic [CFG_W-1:0] grid_rows_r;
  logic [CFG_W-1:0] grid_cols_r;
  logic [CLW-1:0]   col_r;
  logic [RLW-1:0]   row_r;
  res_t             res_r [RES_MAX];
  logic [2:0]       cnt_r;

  logic [CCW-1:0]   cols_c;
  logic [RCW-1:0]   rows_c;
  logic             last_col;
  logic             last_row;
  logic             accept;
  logic             pop;
  cell_ctl_t        ctl;

  win_t             bits    [MAX_COLS];
  logic             in_grid [MAX_COLS];
  logic             wr_en   [MAX_COLS];
  logic             mid_v   [MAX_COLS];
  logic             bot_v   [MAX_COLS];

  res_t             cand    [RES_MAX];
  logic             cand_v  [RES_MAX];
  res_t             list    [RES_MAX];
  logic [2:0]       list_n;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_rows_r <= GRID_ROWS_RST;
      grid_cols_r <= GRID_COLS_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_GRID_ROWS: grid_rows_r <= cfg_wdata;
        CFG_GRID_COLS: grid_cols_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (grid_cols_r == '0) begin
      cols_c = CCW'(1);
    end else if (CCW'(grid_cols_r) > CCW'(MAX_COLS)) begin
      cols_c = CCW'(MAX_COLS);
    end else begin
      cols_c = CCW'(grid_cols_r);
    end
    if (grid_rows_r == '0) begin
      rows_c = RCW'(1);
    end else if (RCW'(grid_rows_r) > RCW'(MAX_ROWS)) begin
      rows_c = RCW'(MAX_ROWS);
    end else begin
      rows_c = RCW'(grid_rows_r);
    end
  end

  assign last_col = (CCW'(col_r) + CCW'(1)) >= cols_c;
  assign last_row = (RCW'(row_r) + RCW'(1)) >= rows_c;

  assign in_chan.ready = (cnt_r == 3'd0) || (cnt_r == 3'd1 && out_chan.ready);
  assign accept        = in_chan.valid && in_chan.ready;
  assign pop           = out_chan.valid && out_chan.ready;

  assign ctl.load  = accept;
  assign ctl.shift = (col_r == '0);
  assign ctl.clear = last_col && last_row;
  assign ctl.din   = in_chan.cell_alive;

  // cell row
  for (genvar k = 0; k < MAX_COLS; k++) begin : g_cell
    win_t lb;
    win_t rb;
    assign in_grid[k] = CCW'(k) < cols_c;
    assign wr_en[k]   = (col_r == CLW'(k));
    if (k == 0) begin : g_l0
      assign lb = '0;
    end else begin : g_l
      assign lb = bits[k-1];
    end
    if (k == MAX_COLS - 1) begin : g_r0
      assign rb = '0;
    end else begin : g_r
      assign rb = bits[k+1];
    end
    lgs_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .wr_en      (wr_en[k]),
      .in_grid    (in_grid[k]),
      .left_bits  (lb),
      .right_bits (rb),
      .own_bits   (bits[k]),
      .life_mid   (mid_v[k]),
      .life_bot   (bot_v[k])
    );
  end

  // result candidates in emission order
  always_comb begin
    logic [CLW-1:0] col_m1;
    logic [RLW-1:0] row_m1;
    logic [CXW-1:0] cx_cur;
    logic [CXW-1:0] cx_m1;
    logic [RXW-1:0] rx_cur;
    logic [RXW-1:0] rx_m1;
    col_m1 = col_r - CLW'(1);
    row_m1 = row_r - RLW'(1);
    cx_cur = CXW'(col_r);
    cx_m1  = CXW'(col_m1);
    rx_cur = RXW'(row_r);
    rx_m1  = RXW'(row_m1);

    cand_v[0] = (row_r != '0) && (col_r != '0);
    cand_v[1] = (row_r != '0) && last_col;
    cand_v[2] = last_row && (col_r != '0);
    cand_v[3] = last_row && last_col;

    cand[0] = '{next_alive: mid_v[col_m1], out_row: rx_m1[COORD_W-1:0],
                out_col: cx_m1[COORD_W-1:0], grid_done: 1'b0};
    cand[1] = '{next_alive: mid_v[col_r], out_row: rx_m1[COORD_W-1:0],
                out_col: cx_cur[COORD_W-1:0], grid_done: 1'b0};
    cand[2] = '{next_alive: bot_v[col_m1], out_row: rx_cur[COORD_W-1:0],
                out_col: cx_m1[COORD_W-1:0], grid_done: 1'b0};
    cand[3] = '{next_alive: bot_v[col_r], out_row: rx_cur[COORD_W-1:0],
                out_col: cx_cur[COORD_W-1:0], grid_done: 1'b1};
  end

  always_comb begin
    list_n = 3'd0;
    for (int i = 0; i < RES_MAX; i++) begin
      list[i] = cand[3];
    end
    for (int i = 0; i < RES_MAX; i++) begin
      if (cand_v[i]) begin
        list[list_n[1:0]] = cand[i];
        list_n = list_n + 3'd1;
      end
    end
  end

  // counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      if (last_col) begin
        col_r <= '0;
        row_r <= last_row ? '0 : row_r + RLW'(1);
      end else begin
        col_r <= col_r + CLW'(1);
      end
    end
  end

  // result buffer, word 0 at the head
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 3'd0;
    end else if (accept) begin
      cnt_r <= list_n;
    end else if (pop) begin
      cnt_r <= cnt_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < RES_MAX; i++) begin
        res_r[i] <= list[i];
      end
    end else if (pop) begin
      for (int i = 0; i < RES_MAX - 1; i++) begin
        res_r[i] <= res_r[i+1];
      end
    end
  end

  assign out_chan.valid      = (cnt_r != 3'd0);
  assign out_chan.next_alive = res_r[0].next_alive;
  assign out_chan.out_row    = res_r[0].out_row;
  assign out_chan.out_col    = res_r[0].out_col;
  assign out_chan.grid_done  = res_r[0].grid_done;

endmodule
